// ===== design/dss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and codes for the dual stack shared store block.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int DEFAULT_STORE_DEPTH = 128;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } dss_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dss_cmd_t;

endpackage

// ===== design/dss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_ctrl
// Sequencer: take a transaction, run it on the datapath, hold the result.
// ----------------------------------------------------------------------------
module dss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output dss_pkg::dss_cmd_t cmd_o
);
  import dss_pkg::*;

  dss_state_t state_r;
  dss_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready     = (state_r == S_IDLE);
    out_tvalid    = (state_r == S_RESP);
    cmd_o.capture = (state_r == S_IDLE) && in_tvalid;
    cmd_o.execute = (state_r == S_EXEC);
  end

endmodule

// ===== design/dss_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_dpath
// Stack counters, shared store and result registers.
// ----------------------------------------------------------------------------
module dss_dpath #(
  parameter int STORE_DEPTH = dss_pkg::DEFAULT_STORE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dss_pkg::dss_cmd_t cmd_i,
  input  logic [1:0]        in_command,
  input  logic              in_stack_select,
  input  logic [31:0]       in_value,
  output logic [31:0]       res_data,
  output logic [1:0]        res_status,
  output logic              res_store_full,
  output logic              res_lower_empty,
  output logic              res_upper_empty
);
  import dss_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [1:0]    command_r;
  logic          sel_r;
  logic [31:0]   value_r;
  logic [CW-1:0] lower_r, lower_nxt;
  logic [CW-1:0] upper_r, upper_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [31:0]   rdata_r;
  logic [CW-1:0] used;
  logic          full;
  logic [CW-1:0] addr_w;
  logic          mem_we;
  logic          mem_re;

  logic [31:0] mem [STORE_DEPTH];

  assign used = lower_r + upper_r;
  assign full = (used == DEPTH_C);

  always_comb begin
    lower_nxt  = lower_r;
    upper_nxt  = upper_r;
    status_nxt = ST_OK;
    rd_ok_nxt  = 1'b0;
    addr_w     = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    case (command_r)
      CMD_PUSH: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else if (!sel_r) begin
          addr_w    = lower_r;
          mem_we    = 1'b1;
          lower_nxt = lower_r + ONE_C;
        end else begin
          addr_w    = DEPTH_C - ONE_C - upper_r;
          mem_we    = 1'b1;
          upper_nxt = upper_r + ONE_C;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (!sel_r) begin
          if (lower_r == '0) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            addr_w    = lower_r - ONE_C;
            mem_re    = 1'b1;
            rd_ok_nxt = 1'b1;
            if (command_r == CMD_POP) lower_nxt = lower_r - ONE_C;
          end
        end else begin
          if (upper_r == '0) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            addr_w    = DEPTH_C - upper_r;
            mem_re    = 1'b1;
            rd_ok_nxt = 1'b1;
            if (command_r == CMD_POP) upper_nxt = upper_r - ONE_C;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      command_r <= in_command;
      sel_r     <= in_stack_select;
      value_r   <= in_value;
    end
    if (cmd_i.execute) begin
      status_r <= status_nxt;
      rd_ok_r  <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= '0;
    end else if (cmd_i.execute) begin
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.execute && mem_we) mem[addr_w[AW-1:0]] <= value_r;
    if (cmd_i.execute && mem_re) rdata_r <= mem[addr_w[AW-1:0]];
  end

  assign res_data        = rd_ok_r ? rdata_r : 32'd0;
  assign res_status      = status_r;
  assign res_store_full  = full;
  assign res_lower_empty = (lower_r == '0);
  assign res_upper_empty = (upper_r == '0);

endmodule

// ===== design/dual_stack_shared_store_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_store_top
// Two LIFO stacks in one store: lower grows up from 0, upper grows down.
// Each transaction passes the take, store access and result states in order;
// a new one is taken only after the previous result has been taken.
// The store has a single port, used for both the write and the registered read.
// Reset clears both stack counts; store contents stay undefined until pushed.
// ----------------------------------------------------------------------------
module dual_stack_shared_store_top #(
  parameter int STORE_DEPTH = dss_pkg::DEFAULT_STORE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [2:0]  in_tuser,   // command[1:0], stack_select[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // data[31:0], store_full[32], lower_empty[33],
                                  // upper_empty[34], zero[39:35]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import dss_pkg::*;

  dss_cmd_t    cmd;
  logic [31:0] res_data;
  logic [1:0]  res_status;
  logic        res_store_full;
  logic        res_lower_empty;
  logic        res_upper_empty;

  dss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd_o      (cmd)
  );

  dss_dpath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .in_command      (in_tuser[1:0]),
    .in_stack_select (in_tuser[2]),
    .in_value        (in_tdata),
    .res_data        (res_data),
    .res_status      (res_status),
    .res_store_full  (res_store_full),
    .res_lower_empty (res_lower_empty),
    .res_upper_empty (res_upper_empty)
  );

  assign out_tdata = {5'd0, res_upper_empty, res_lower_empty, res_store_full, res_data};
  assign out_tuser = res_status;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and result channels active together");

  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid && !in_tready)
    else $error("result or new transaction right after accept");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_OVERFLOW) |-> out_tdata[32])
    else $error("overflow reported on a store that is not full");

  a_udf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_UNDERFLOW) |-> (out_tdata[31:0] == 32'd0))
    else $error("underflow with nonzero data");

  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32]) |-> !(out_tdata[33] && out_tdata[34]))
    else $error("store full while both stacks empty");

endmodule

// ===== tb/sv/tb_dual_stack_shared_store_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_stack_shared_store_top
// Drives push, pop, peek and unused commands into the shared two-stack store.
// Each accepted transaction is run through a software copy of both stacks.
// Every response is checked field by field against the oldest predicted one.
// Both sides stall in random bursts, except in a quiet final stretch.
// ----------------------------------------------------------------------------
module tb_dual_stack_shared_store_top;
  import dss_pkg::*;

  localparam int         DEPTH    = DEFAULT_STORE_DEPTH;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic       SEL_LOW  = 1'b0;
  localparam logic       SEL_HIGH = 1'b1;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
    logic        full;
    logic        lower_empty;
    logic        upper_empty;
  } stack_resp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  // software copy of the stacks
  logic [31:0] word_mem [DEPTH];
  int          lower_fill;
  int          upper_fill;

  stack_resp_t pending_resp_q [$];
  bit          idle_en;
  int          errors;
  int          n_checked;
  int          n_overflow;
  int          n_underflow;
  int          peak_fill;

  dual_stack_shared_store_top #(
    .STORE_DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic stack_resp_t apply_stack_op(input logic [1:0] cmd, input logic sel,
                                                 input logic [31:0] val);
    stack_resp_t r;
    r = '0;
    r.status = ST_OK;
    if (cmd == CMD_PUSH) begin
      if (lower_fill + upper_fill >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else if (sel == SEL_LOW) begin
        word_mem[lower_fill] = val;
        lower_fill++;
      end else begin
        upper_fill++;
        word_mem[DEPTH - upper_fill] = val;
      end
    end else if (cmd == CMD_POP || cmd == CMD_PEEK) begin
      if (sel == SEL_LOW) begin
        if (lower_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.data = word_mem[lower_fill - 1];
          if (cmd == CMD_POP) lower_fill--;
        end
      end else begin
        if (upper_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.data = word_mem[DEPTH - upper_fill];
          if (cmd == CMD_POP) upper_fill--;
        end
      end
    end
    r.full        = (lower_fill + upper_fill >= DEPTH);
    r.lower_empty = (lower_fill == 0);
    r.upper_empty = (upper_fill == 0);
    return r;
  endfunction

  task automatic send_op(input logic [1:0] cmd, input logic sel, input logic [31:0] val);
    stack_resp_t r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {sel, cmd};
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_stack_op(cmd, sel, val);
    if (r.status == ST_OVERFLOW) n_overflow++;
    if (r.status == ST_UNDERFLOW) n_underflow++;
    if (lower_fill + upper_fill > peak_fill) peak_fill = lower_fill + upper_fill;
    pending_resp_q.push_back(r);
  endtask

  // result side back-pressure
  initial begin
    int n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 13);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 20);
      end
      repeat (n - 1) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    stack_resp_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_resp_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h/%h", $time,
                 out_tdata, out_tuser);
        errors++;
      end else begin
        exp_r = pending_resp_q.pop_front();
        n_checked++;
        check_field("data", exp_r.data, out_tdata[31:0]);
        check_field("status", {30'd0, exp_r.status}, {30'd0, out_tuser});
        check_field("store_full", {31'd0, exp_r.full}, {31'd0, out_tdata[32]});
        check_field("lower_empty", {31'd0, exp_r.lower_empty}, {31'd0, out_tdata[33]});
        check_field("upper_empty", {31'd0, exp_r.upper_empty}, {31'd0, out_tdata[34]});
      end
    end
  end

  task automatic test_empty_stacks();
    send_op(CMD_POP, SEL_LOW, 32'h0);
    send_op(CMD_POP, SEL_HIGH, 32'hFFFF_FFFF);
    send_op(CMD_PEEK, SEL_LOW, 32'h1234_5678);
    send_op(CMD_PEEK, SEL_HIGH, 32'h0);
  endtask

  task automatic test_value_extremes();
    send_op(CMD_PUSH, SEL_LOW, 32'h8000_0000);
    send_op(CMD_PUSH, SEL_HIGH, 32'h7FFF_FFFF);
    send_op(CMD_PUSH, SEL_LOW, 32'hFFFF_FFFF);
    send_op(CMD_PUSH, SEL_HIGH, 32'h0000_0000);
    send_op(CMD_PEEK, SEL_LOW, 32'hA5A5_A5A5);
    send_op(CMD_PEEK, SEL_HIGH, 32'h5A5A_5A5A);
    send_op(CMD_POP, SEL_LOW, 32'h0);
    send_op(CMD_POP, SEL_LOW, 32'h0);
    send_op(CMD_POP, SEL_HIGH, 32'hFFFF_FFFF);
    send_op(CMD_PEEK, SEL_HIGH, 32'h0);
    send_op(CMD_POP, SEL_HIGH, 32'h0);
  endtask

  task automatic test_unused_command();
    send_op(CMD_NONE, SEL_LOW, 32'hFFFF_FFFF);
    send_op(CMD_PUSH, SEL_LOW, 32'hDEAD_BEEF);
    send_op(CMD_NONE, SEL_HIGH, 32'h0000_0001);
    send_op(CMD_NONE, SEL_LOW, 32'h0);
    send_op(CMD_POP, SEL_LOW, 32'h0);
  endtask

  // push_pct sets the bias: high fills the store toward overflow, low drains it
  task automatic test_random_ops(input int count, input int push_pct);
    int          r;
    logic [1:0]  cmd;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) cmd = CMD_PUSH;
      else if (r < 97) cmd = ($urandom_range(0, 2) != 0) ? CMD_POP : CMD_PEEK;
      else cmd = CMD_NONE;
      send_op(cmd, 1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  initial begin
    errors      = 0;
    n_checked   = 0;
    n_overflow  = 0;
    n_underflow = 0;
    peak_fill   = 0;
    lower_fill  = 0;
    upper_fill  = 0;
    idle_en     = 1'b1;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stacks();
    test_value_extremes();
    test_unused_command();
    test_random_ops(300, 85);
    test_random_ops(300, 15);
    test_random_ops(200, 50);
    test_random_ops(200, 85);
    idle_en = 1'b0;
    test_random_ops(100, 50);

    in_tvalid <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d responses: %0d overflows, %0d underflows, peak fill %0d of %0d.",
             n_checked, n_overflow, n_underflow, peak_fill, DEPTH);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
